// ===== rtl/sdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrc_pkg
// Shared constants, register indexes and the command/status bundles that
// join the drift corrector controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sdrc_pkg;

   // checkpoint store geometry
   localparam int CK_DEPTH = 16;
   localparam int CK_IDX_W = $clog2(CK_DEPTH);
   localparam int CK_CNT_W = $clog2(CK_DEPTH + 1);

   // shared divider geometry
   localparam int DIV_N_W   = 67;
   localparam int DIV_D_W   = 46;
   localparam int DIV_CNT_W = 7;

   // configuration register indexes
   localparam logic [1:0] CSR_TEMP_COEFF = 2'd0;
   localparam logic [1:0] CSR_TEMP_REF   = 2'd1;
   localparam logic [1:0] CSR_REF_LEVEL  = 2'd2;
   localparam logic [1:0] CSR_WINDOW     = 2'd3;

   // partial product selects for the numerator build
   localparam logic [1:0] PP_P_LO  = 2'd0;
   localparam logic [1:0] PP_P_HI  = 2'd1;
   localparam logic [1:0] PP_D_LO  = 2'd2;
   localparam logic [1:0] PP_D_HI  = 2'd3;

   typedef struct packed {
      logic       load;
      logic       store;
      logic       fact;
      logic       cdiv_start;
      logic       comp_pass;
      logic       walk_start;
      logic       mul;
      logic       diff;
      logic       pp_go;
      logic [1:0] pp_sel;
      logic       qdiv_start;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic f_pos;
      logic div_done;
      logic walk_done;
      logic fit_ok;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/sdrc_div.sv =====
// ----------------------------------------------------------------------------
// sdrc_div
// Restoring unsigned divider, one quotient bit per cycle. Shared by the
// temperature compensation and the drift prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [sdrc_pkg::DIV_N_W-1:0]  dividend,
   input  wire logic [sdrc_pkg::DIV_D_W-1:0]  divisor,
   output logic                               done,
   output logic [sdrc_pkg::DIV_N_W-1:0]       quotient
);

   logic [sdrc_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [sdrc_pkg::DIV_D_W:0]     rem_ff, rem_in;
   logic [sdrc_pkg::DIV_D_W-1:0]   den_ff, den_in;
   logic [sdrc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [sdrc_pkg::DIV_D_W:0]     rem_sh;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[sdrc_pkg::DIV_D_W-1:0], quo_ff[sdrc_pkg::DIV_N_W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = sdrc_pkg::DIV_CNT_W'(sdrc_pkg::DIV_N_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[sdrc_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[sdrc_pkg::DIV_N_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/sdrc_datapath.sv =====
// ----------------------------------------------------------------------------
// sdrc_datapath
// Configuration registers, checkpoint store, fit sums, numerator builder,
// shared divider and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrc_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sdrc_pkg::cmd_type              cmd,
   output sdrc_pkg::status_type                status,
   input  wire logic                           req_kind,
   input  wire logic [15:0]                    req_day_index,
   input  wire logic [15:0]                    req_value_ppm,
   input  wire logic signed [11:0]             req_temperature,
   input  wire logic                           csr_valid,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [15:0]                    csr_wdata,
   output logic                                rsp_valid,
   output logic signed [16:0]                  rsp_corrected_ppm,
   output logic                                rsp_fit_used,
   output logic                                rsp_temp_guard,
   output logic [4:0]                          rsp_stored_count
);

   localparam int IW = sdrc_pkg::CK_IDX_W;
   localparam int CW = sdrc_pkg::CK_CNT_W;

   // configuration
   logic [15:0]        coeff_ff;
   logic signed [11:0] tref_ff;
   logic [15:0]        rlev_ff;
   logic [15:0]        wdays_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= 16'd1311;
         tref_ff  <= 12'sd400;
         rlev_ff  <= 16'd0;
         wdays_ff <= 16'd30;
      end else if (csr_valid) begin
         unique case (csr_index)
            sdrc_pkg::CSR_TEMP_COEFF: coeff_ff <= csr_wdata;
            sdrc_pkg::CSR_TEMP_REF:   tref_ff  <= csr_wdata[11:0];
            sdrc_pkg::CSR_REF_LEVEL:  rlev_ff  <= csr_wdata;
            sdrc_pkg::CSR_WINDOW:     wdays_ff <= csr_wdata;
            default:                  coeff_ff <= coeff_ff;
         endcase
      end
   end

   // latched transaction
   logic               kind_ff;
   logic [15:0]        day_ff, val_ff;
   logic signed [11:0] temp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         day_ff  <= req_day_index;
         val_ff  <= req_value_ppm;
         temp_ff <= req_temperature;
      end
   end

   // checkpoint store bookkeeping
   logic [31:0]   mem [sdrc_pkg::CK_DEPTH];
   logic [CW-1:0] count_ff;
   logic [IW-1:0] oldest_ff;
   logic [IW-1:0] waddr;

   assign waddr = oldest_ff + count_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[waddr] <= {day_ff, val_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         oldest_ff <= '0;
      end else if (cmd.store) begin
         if (count_ff < CW'(sdrc_pkg::CK_DEPTH)) begin
            count_ff <= count_ff + 1'b1;
         end else begin
            oldest_ff <= oldest_ff + 1'b1;
         end
      end
   end

   // temperature factor and window start
   logic signed [12:0] tdiff;
   logic signed [29:0] tprod;
   logic signed [30:0] f_ff;
   logic [15:0]        wstart_ff;

   assign tdiff = 13'(temp_ff) - 13'(tref_ff);
   assign tprod = $signed({1'b0, coeff_ff}) * tdiff;

   always_ff @(posedge clock) begin
      if (cmd.fact) begin
         f_ff      <= 31'sd1048576 + 31'(tprod);
         wstart_ff <= (day_ff > wdays_ff) ? day_ff - wdays_ff : 16'd0;
      end
   end

   // walk over stored checkpoints: read, multiply, accumulate
   logic [CW-1:0]      rd_cnt_ff;
   logic               issue_ff, v1_ff, v2_ff, walk_act_ff;
   logic [31:0]        rdata_ff;
   logic [15:0]        x2_ff;
   logic signed [16:0] y2_ff;
   logic signed [33:0] xy_ff;
   logic [31:0]        xx_ff;
   logic [15:0]        x1;
   logic signed [16:0] y1;
   logic [19:0]        sx_ff;
   logic signed [20:0] sy_ff;
   logic signed [36:0] sxy_ff;
   logic [35:0]        sxx_ff;
   logic [CW-1:0]      n_ff;
   logic               walk_done;

   assign x1 = rdata_ff[31:16];
   assign y1 = $signed({1'b0, rdata_ff[15:0]}) - $signed({1'b0, rlev_ff});
   assign walk_done = walk_act_ff && !issue_ff && !v1_ff && !v2_ff;

   always_ff @(posedge clock) begin
      if (issue_ff) begin
         rdata_ff <= mem[oldest_ff + rd_cnt_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         walk_act_ff <= 1'b0;
      end else begin
         v1_ff <= issue_ff;
         v2_ff <= v1_ff && (x1 >= wstart_ff);
         if (cmd.walk_start) begin
            issue_ff    <= (count_ff != '0);
            walk_act_ff <= 1'b1;
         end else begin
            if (issue_ff) begin
               issue_ff <= (rd_cnt_ff + 1'b1) < count_ff;
            end
            if (walk_done) begin
               walk_act_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         rd_cnt_ff <= '0;
      end else if (issue_ff) begin
         rd_cnt_ff <= rd_cnt_ff + 1'b1;
      end
      x2_ff <= x1;
      y2_ff <= y1;
      xy_ff <= $signed({1'b0, x1}) * y1;
      xx_ff <= x1 * x1;
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sxx_ff <= '0;
         n_ff   <= '0;
      end else if (v2_ff) begin
         sx_ff  <= sx_ff + 20'(x2_ff);
         sy_ff  <= sy_ff + 21'(y2_ff);
         sxy_ff <= sxy_ff + 37'(xy_ff);
         sxx_ff <= sxx_ff + 36'(xx_ff);
         n_ff   <= n_ff + 1'b1;
      end
   end

   // normal-equation terms
   logic [40:0]        t1_ff;
   logic [39:0]        t2_ff;
   logic signed [41:0] t3_ff;
   logic signed [40:0] t4_ff;
   logic [20:0]        t5_ff;
   logic [40:0]        d_ff;
   logic signed [42:0] p_ff;
   logic signed [20:0] e_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         t1_ff <= n_ff * sxx_ff;
         t2_ff <= sx_ff * sx_ff;
         t3_ff <= $signed({1'b0, n_ff}) * sxy_ff;
         t4_ff <= $signed({1'b0, sx_ff}) * sy_ff;
         t5_ff <= n_ff * day_ff;
      end
      if (cmd.diff) begin
         d_ff <= t1_ff - 41'(t2_ff);
         p_ff <= 43'(t3_ff) - 43'(t4_ff);
         e_ff <= $signed(t5_ff) - $signed({1'b0, sx_ff});
      end
   end

   // numerator = P*e + Sy*D from four partial products on one multiplier
   logic [42:0]        pmag;
   logic [20:0]        emag, symag;
   logic [21:0]        mul_a;
   logic [20:0]        mul_b;
   logic               mul_neg;
   logic [42:0]        prod_ff;
   logic               pneg_ff, pshift_ff, pv_ff;
   logic signed [66:0] num_ff;
   logic [66:0]        pterm;
   logic [45:0]        nd_ff;

   assign pmag  = p_ff[42] ? 43'(-p_ff) : 43'(p_ff);
   assign emag  = e_ff[20] ? 21'(-e_ff) : 21'(e_ff);
   assign symag = sy_ff[20] ? 21'(-sy_ff) : 21'(sy_ff);

   always_comb begin
      unique case (cmd.pp_sel)
         sdrc_pkg::PP_P_LO: begin
            mul_a = pmag[21:0];
            mul_b = emag;
            mul_neg = p_ff[42] ^ e_ff[20];
         end
         sdrc_pkg::PP_P_HI: begin
            mul_a = {1'b0, pmag[42:22]};
            mul_b = emag;
            mul_neg = p_ff[42] ^ e_ff[20];
         end
         sdrc_pkg::PP_D_LO: begin
            mul_a = d_ff[21:0];
            mul_b = symag;
            mul_neg = sy_ff[20];
         end
         default: begin
            mul_a = {3'b0, d_ff[40:22]};
            mul_b = symag;
            mul_neg = sy_ff[20];
         end
      endcase
   end

   assign pterm = pshift_ff ? {2'b0, prod_ff, 22'b0} : {24'b0, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.pp_go;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pp_go) begin
         prod_ff   <= mul_a * mul_b;
         pneg_ff   <= mul_neg;
         pshift_ff <= cmd.pp_sel[0];
      end
      if (cmd.pp_go && cmd.pp_sel == sdrc_pkg::PP_P_LO) begin
         nd_ff <= n_ff * d_ff;
      end
      if (cmd.diff) begin
         num_ff <= '0;
      end else if (pv_ff) begin
         num_ff <= pneg_ff ? num_ff - $signed(pterm) : num_ff + $signed(pterm);
      end
   end

   // shared divider
   logic [66:0] numabs;
   logic [66:0] div_n;
   logic [45:0] div_d;
   logic        div_start, div_done;
   logic [66:0] div_q;
   logic        csel_ff;
   logic [36:0] comp_ff;
   logic        neg_ff, fit_ff, guard_ff;

   assign numabs    = num_ff[66] ? 67'(-num_ff) : 67'(num_ff);
   assign div_start = cmd.cdiv_start || cmd.qdiv_start;

   always_comb begin
      if (cmd.qdiv_start) begin
         div_n = numabs + 67'(nd_ff[45:1]);
         div_d = nd_ff;
      end else begin
         div_n = 67'({val_ff, 20'b0}) + 67'(f_ff[30:1]);
         div_d = 46'(f_ff[30:0]);
      end
   end

   sdrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (div_start) begin
         csel_ff <= cmd.cdiv_start;
      end
      if (cmd.qdiv_start) begin
         neg_ff <= num_ff[66];
      end
      if (div_done && csel_ff) begin
         comp_ff <= div_q[36:0];
      end else if (cmd.comp_pass) begin
         comp_ff <= 37'(val_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         fit_ff   <= 1'b0;
         guard_ff <= 1'b0;
      end else begin
         if (cmd.qdiv_start) begin
            fit_ff <= 1'b1;
         end
         if (cmd.comp_pass) begin
            guard_ff <= 1'b1;
         end
      end
   end

   // final subtraction and saturation
   logic signed [68:0] compx, qx, corr;
   logic signed [16:0] sat;

   assign compx = $signed({32'b0, comp_ff});
   assign qx    = $signed({2'b0, div_q});

   always_comb begin
      if (!fit_ff) begin
         corr = compx;
      end else if (neg_ff) begin
         corr = compx + qx;
      end else begin
         corr = compx - qx;
      end
      if (corr > 69'sd65535) begin
         sat = 17'sd65535;
      end else if (corr < -69'sd65536) begin
         sat = -17'sd65536;
      end else begin
         sat = corr[16:0];
      end
   end

   // result register
   logic               rv_ff;
   logic signed [16:0] rcorr_ff;
   logic               rfit_ff, rguard_ff;
   logic [4:0]         rcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rcorr_ff  <= kind_ff ? sat : 17'sd0;
         rfit_ff   <= kind_ff & fit_ff;
         rguard_ff <= kind_ff & guard_ff;
         rcount_ff <= 5'(count_ff);
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_corrected_ppm = rcorr_ff;
   assign rsp_fit_used      = rfit_ff;
   assign rsp_temp_guard    = rguard_ff;
   assign rsp_stored_count  = rcount_ff;

   // status to controller
   assign status.kind      = kind_ff;
   assign status.f_pos     = !f_ff[30] && (f_ff != '0);
   assign status.div_done  = div_done;
   assign status.walk_done = walk_done;
   assign status.fit_ok    = (n_ff >= CW'(2)) && (d_ff != '0);

endmodule

`default_nettype wire

// ===== rtl/sdrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdrc_ctrl
// Sequencer: steps one transaction through store update or compensation,
// checkpoint walk, fit terms, numerator build and prediction divide.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output sdrc_pkg::cmd_type         cmd,
   input  wire sdrc_pkg::status_type status
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_DISP  = 5'd1;
   localparam logic [4:0] ST_CKPT  = 5'd2;
   localparam logic [4:0] ST_FACT  = 5'd3;
   localparam logic [4:0] ST_CCHK  = 5'd4;
   localparam logic [4:0] ST_CWAIT = 5'd5;
   localparam logic [4:0] ST_WALK  = 5'd6;
   localparam logic [4:0] ST_WWAIT = 5'd7;
   localparam logic [4:0] ST_MUL   = 5'd8;
   localparam logic [4:0] ST_DIFF  = 5'd9;
   localparam logic [4:0] ST_FCHK  = 5'd10;
   localparam logic [4:0] ST_PP0   = 5'd11;
   localparam logic [4:0] ST_PP1   = 5'd12;
   localparam logic [4:0] ST_PP2   = 5'd13;
   localparam logic [4:0] ST_PP3   = 5'd14;
   localparam logic [4:0] ST_PPACC = 5'd15;
   localparam logic [4:0] ST_QDIV  = 5'd16;
   localparam logic [4:0] ST_QWAIT = 5'd17;
   localparam logic [4:0] ST_EMIT  = 5'd18;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            state_in = status.kind ? ST_FACT : ST_CKPT;
         end
         ST_CKPT: begin
            cmd.store = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_FACT: begin
            cmd.fact = 1'b1;
            state_in = ST_CCHK;
         end
         ST_CCHK: begin
            if (status.f_pos) begin
               cmd.cdiv_start = 1'b1;
               state_in       = ST_CWAIT;
            end else begin
               cmd.comp_pass = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_CWAIT: begin
            if (status.div_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk_start = 1'b1;
            state_in       = ST_WWAIT;
         end
         ST_WWAIT: begin
            if (status.walk_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            state_in = status.fit_ok ? ST_PP0 : ST_EMIT;
         end
         ST_PP0: begin
            cmd.pp_go  = 1'b1;
            cmd.pp_sel = sdrc_pkg::PP_P_LO;
            state_in   = ST_PP1;
         end
         ST_PP1: begin
            cmd.pp_go  = 1'b1;
            cmd.pp_sel = sdrc_pkg::PP_P_HI;
            state_in   = ST_PP2;
         end
         ST_PP2: begin
            cmd.pp_go  = 1'b1;
            cmd.pp_sel = sdrc_pkg::PP_D_LO;
            state_in   = ST_PP3;
         end
         ST_PP3: begin
            cmd.pp_go  = 1'b1;
            cmd.pp_sel = sdrc_pkg::PP_D_HI;
            state_in   = ST_PPACC;
         end
         ST_PPACC: begin
            state_in = ST_QDIV;
         end
         ST_QDIV: begin
            cmd.qdiv_start = 1'b1;
            state_in       = ST_QWAIT;
         end
         ST_QWAIT: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/sensor_drift_regression_corrector.sv =====
// ----------------------------------------------------------------------------
// sensor_drift_regression_corrector
// Temperature compensation plus least-squares drift correction against
// rolling calibration checkpoints.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. kind 0 stores
//   a (day, value) checkpoint in a 16-entry ring, dropping the oldest when
//   full; kind 1 corrects a reading. Every transaction returns one result on
//   the rsp_ ports, marked by rsp_valid for a single cycle; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   The shared one-bit-per-cycle 67-step divider runs once for the
//   temperature factor and, when a fit is used, once for the drift
//   prediction. When the factor is not positive the first divide is
//   skipped. One transaction is in flight at a time; busy drops in the
//   cycle rsp_valid is high, so the next start is taken there.
//   Registers are written through csr_valid/csr_index/csr_wdata (always
//   ready); the user must write them only while the block is idle. The
//   block itself does not enforce this.
//   Reset restores register defaults and empties the checkpoint ring; the
//   ring contents need no clearing since only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_drift_regression_corrector (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_kind,
   input  wire logic [15:0]        req_day_index,
   input  wire logic [15:0]        req_value_ppm,
   input  wire logic signed [11:0] req_temperature,
   output logic                    rsp_valid,
   output logic signed [16:0]      rsp_corrected_ppm,
   output logic                    rsp_fit_used,
   output logic                    rsp_temp_guard,
   output logic [4:0]              rsp_stored_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   sdrc_pkg::cmd_type    cmd;
   sdrc_pkg::status_type status;

   assign csr_ready = 1'b1;

   sdrc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   sdrc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_day_index     (req_day_index),
      .req_value_ppm     (req_value_ppm),
      .req_temperature   (req_temperature),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_corrected_ppm (rsp_corrected_ppm),
      .rsp_fit_used      (rsp_fit_used),
      .rsp_temp_guard    (rsp_temp_guard),
      .rsp_stored_count  (rsp_stored_count)
   );

endmodule

`default_nettype wire

// ===== bench/tb_sensor_drift_regression_corrector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_drift_regression_corrector
// Drives checkpoint and reading transactions with random idle bursts, keeps
// its own copy of the checkpoint ring and registers, predicts every result
// (temperature compensation plus least-squares drift fit) and compares it
// field by field against the result strobes. Register settings are swept
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_sensor_drift_regression_corrector;

   localparam logic KIND_CHECKPOINT = 1'b0;
   localparam logic KIND_READING    = 1'b1;
   localparam int   STALL_LIMIT     = 4000;
   localparam int   RING_DEPTH      = sdrc_pkg::CK_DEPTH;

   typedef struct {
      logic signed [16:0] corrected;
      logic               fit;
      logic               guard;
      logic [4:0]         count;
   } drift_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic [15:0] req_day_index = '0;
   logic [15:0] req_value_ppm = '0;
   logic signed [11:0] req_temperature = '0;
   logic rsp_valid;
   logic signed [16:0] rsp_corrected_ppm;
   logic rsp_fit_used;
   logic rsp_temp_guard;
   logic [4:0] rsp_stored_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sensor_drift_regression_corrector uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_day_index(req_day_index),
      .req_value_ppm(req_value_ppm), .req_temperature(req_temperature),
      .rsp_valid(rsp_valid), .rsp_corrected_ppm(rsp_corrected_ppm),
      .rsp_fit_used(rsp_fit_used), .rsp_temp_guard(rsp_temp_guard),
      .rsp_stored_count(rsp_stored_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state: registers and checkpoint ring
   logic [15:0]        cfg_coeff;
   logic signed [11:0] cfg_tref;
   logic [15:0]        cfg_level;
   logic [15:0]        cfg_window;
   logic [15:0]        ring_day [RING_DEPTH];
   logic [15:0]        ring_val [RING_DEPTH];
   int                 ring_count;
   int                 ring_oldest;

   drift_result_type pending_results[$];
   int  error_count = 0;
   bit  idle_enabled = 1'b1;
   int  activity = 0;
   longint cur_day = 100;

   // predicted outcome of one transaction; updates the ring for checkpoints
   function automatic drift_result_type correct_reading(logic kind, logic [15:0] day,
         logic [15:0] val, logic signed [11:0] temp);
      drift_result_type r;
      longint f, comp, start_day, sx, sy, sxy, sxx, n, x, y, den, p, pred, corr;
      logic signed [127:0] a, b, c, d, num;
      logic [127:0] mag, q;
      r.corrected = '0;
      r.fit = 1'b0;
      r.guard = 1'b0;
      if (kind == KIND_CHECKPOINT) begin
         if (ring_count < RING_DEPTH) begin
            ring_day[(ring_oldest + ring_count) % RING_DEPTH] = day;
            ring_val[(ring_oldest + ring_count) % RING_DEPTH] = val;
            ring_count++;
         end else begin
            ring_day[ring_oldest] = day;
            ring_val[ring_oldest] = val;
            ring_oldest = (ring_oldest + 1) % RING_DEPTH;
         end
      end else begin
         f = (longint'(1) << 20) + longint'(cfg_coeff) * (longint'(temp) - longint'(cfg_tref));
         if (f <= 0) begin
            r.guard = 1'b1;
            comp = longint'(val);
         end else begin
            comp = ((longint'(val) << 20) + f / 2) / f;
         end
         start_day = (longint'(day) > longint'(cfg_window)) ?
                     longint'(day) - longint'(cfg_window) : 0;
         sx = 0; sy = 0; sxy = 0; sxx = 0; n = 0;
         for (int i = 0; i < ring_count; i++) begin
            x = longint'(ring_day[(ring_oldest + i) % RING_DEPTH]);
            y = longint'(ring_val[(ring_oldest + i) % RING_DEPTH]) - longint'(cfg_level);
            if (x >= start_day) begin
               sx += x; sy += y; sxy += x * y; sxx += x * x; n++;
            end
         end
         corr = comp;
         if (n >= 2) begin
            den = n * sxx - sx * sx;
            if (den != 0) begin
               p = n * sxy - sx * sy;
               a = p; b = n * longint'(day) - sx; c = sy; d = den;
               num = a * b + c * d;
               mag = (num < 0) ? -num : num;
               mag = mag + ((n * den) >> 1);
               q = mag / (n * den);
               if (q > (128'd1 << 62)) q = 128'd1 << 62;
               pred = (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
               corr = comp - pred;
               r.fit = 1'b1;
            end
         end
         if (corr > 65535) corr = 65535;
         if (corr < -65536) corr = -65536;
         r.corrected = corr[16:0];
      end
      r.count = ring_count[4:0];
      return r;
   endfunction

   // send one transaction; start stays high until the caller idles
   task automatic send_item(logic kind, logic [15:0] day, logic [15:0] val,
         logic signed [11:0] temp);
      @(negedge clock);
      start = 1'b1;
      req_kind = kind;
      req_day_index = day;
      req_value_ppm = val;
      req_temperature = temp;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_results.push_back(correct_reading(kind, day, val, temp));
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic maybe_idle();
      if (idle_enabled && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 5));
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      drain();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         sdrc_pkg::CSR_TEMP_COEFF: cfg_coeff = data;
         sdrc_pkg::CSR_TEMP_REF:   cfg_tref = data[11:0];
         sdrc_pkg::CSR_REF_LEVEL:  cfg_level = data;
         default:                  cfg_window = data;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(logic [15:0] coeff, logic [15:0] tref, logic [15:0] level,
         logic [15:0] window);
      write_reg(sdrc_pkg::CSR_TEMP_COEFF, coeff);
      write_reg(sdrc_pkg::CSR_TEMP_REF, tref);
      write_reg(sdrc_pkg::CSR_REF_LEVEL, level);
      write_reg(sdrc_pkg::CSR_WINDOW, window);
   endtask

   // result checker
   always @(posedge clock) begin
      drift_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result corrected=%0d", $time, rsp_corrected_ppm);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_corrected_ppm !== e.corrected) begin
               $display("%0t: corrected_ppm expected %0d actual %0d", $time,
                        e.corrected, rsp_corrected_ppm);
               error_count++;
            end
            if (rsp_fit_used !== e.fit) begin
               $display("%0t: fit_used expected %0b actual %0b", $time, e.fit, rsp_fit_used);
               error_count++;
            end
            if (rsp_temp_guard !== e.guard) begin
               $display("%0t: temp_guard expected %0b actual %0b", $time,
                        e.guard, rsp_temp_guard);
               error_count++;
            end
            if (rsp_stored_count !== e.count) begin
               $display("%0t: stored_count expected %0d actual %0d", $time,
                        e.count, rsp_stored_count);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
         activity <= 0;
      end else begin
         activity <= activity + 1;
         if (activity >= STALL_LIMIT) begin
            $display("tb_sensor_drift_regression_corrector: errors");
            $finish;
         end
      end
   end

   // directed: field extremes, guard, few points, same day, ring overflow
   task automatic test_directed();
      send_item(KIND_READING, 16'd0, 16'd0, 12'sd0);
      send_item(KIND_READING, 16'hFFFF, 16'hFFFF, 12'sd2047);
      send_item(KIND_READING, 16'd5, 16'd1000, -12'sd2048);
      send_item(KIND_CHECKPOINT, 16'd10, 16'd500, 12'sd0);
      send_item(KIND_READING, 16'd12, 16'd500, 12'sd400);
      send_item(KIND_CHECKPOINT, 16'd10, 16'd900, 12'sd0);
      send_item(KIND_READING, 16'd12, 16'd500, 12'sd400);
      for (int i = 0; i < 18; i++) begin
         send_item(KIND_CHECKPOINT, 16'(20 + i), 16'(1000 + 37 * i), 12'sd0);
         maybe_idle();
      end
      send_item(KIND_READING, 16'd40, 16'd1200, 12'sd600);
      send_item(KIND_READING, 16'd0, 16'hFFFF, 12'sd0);
      write_reg(sdrc_pkg::CSR_TEMP_COEFF, 16'hFFFF);
      send_item(KIND_READING, 16'd45, 16'hFFFF, -12'sd2048);
      send_item(KIND_READING, 16'd45, 16'd0, 12'sd2047);
   endtask

   task automatic random_item(int day_spread);
      logic kind;
      logic [15:0] val;
      if ($urandom_range(0, 19) == 0) begin
         send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 12'($urandom));
      end else begin
         kind = ($urandom_range(0, 2) == 0) ? KIND_CHECKPOINT : KIND_READING;
         cur_day += $urandom_range(0, 2);
         if (cur_day > 65535) cur_day = $urandom_range(0, 200);
         val = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
               16'(cfg_level + cur_day[7:0] + $urandom_range(0, 300));
         if (kind == KIND_CHECKPOINT)
            send_item(kind, 16'(cur_day - $urandom_range(0, day_spread)), val, 12'sd0);
         else
            send_item(kind, 16'(cur_day), val, 12'($urandom_range(0, 2640) - 640));
      end
      maybe_idle();
   endtask

   // register sweep through several settings, extremes included
   task automatic test_config_sweep();
      logic [15:0] coeffs [5] = '{16'd0, 16'hFFFF, 16'd1311, 16'd40000, 16'd7};
      logic [15:0] trefs  [5] = '{16'h0800, 16'hF7FF, 16'h0190, 16'h3D80, 16'h07D0};
      logic [15:0] levels [5] = '{16'd0, 16'hFFFF, 16'd800, 16'd12345, 16'd0};
      logic [15:0] wins   [5] = '{16'd0, 16'hFFFF, 16'd30, 16'd5, 16'd100};
      for (int s = 0; s < 5; s++) begin
         write_all(coeffs[s], trefs[s], levels[s], wins[s]);
         repeat (40) random_item(40);
      end
   endtask

   task automatic test_random();
      for (int i = 0; i < 1200; i++) begin
         if (i % 200 == 199)
            write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4000)),
                      16'($urandom_range(0, 60)));
         if (i == 500) drain();
         if (i >= 1050) idle_enabled = 1'b0;
         random_item((i % 3 == 0) ? 80 : 30);
      end
   endtask

   initial begin
      cfg_coeff = 16'd1311;
      cfg_tref = 12'sd400;
      cfg_level = 16'd0;
      cfg_window = 16'd30;
      ring_count = 0;
      ring_oldest = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_sweep();
      test_random();
      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("tb_sensor_drift_regression_corrector: clean");
      else
         $display("tb_sensor_drift_regression_corrector: errors");
      $finish;
   end
endmodule
